// File: design/grd_pkg.sv
// Package for the grid ray walker: beat structs, microcode types, result codes
// and the wall color table. No dependencies.
package grd_pkg;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 12;
	localparam int UPC_BITS       = 3;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [UPC_BITS-1:0]       upc_t;

	localparam cfg_index_t CFG_MAX_STEPS   = 1'b0;
	localparam cfg_index_t CFG_SEE_THROUGH = 1'b1;

	localparam logic [11:0] MAX_STEPS_RESET   = 12'd256;
	localparam logic [3:0]  SEE_THROUGH_RESET = 4'd6;
	localparam logic [12:0] STEP_LIMIT_ZERO   = 13'd4096;
	localparam logic [7:0]  COLOUR_CODES      = 8'd5;

	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_HIT     = 2'd1;
	localparam logic [1:0] ST_LEFT    = 2'd2;
	localparam logic [1:0] ST_LIMIT   = 2'd3;

	localparam logic [1:0] SIDE_XN = 2'd0;
	localparam logic [1:0] SIDE_XP = 2'd1;
	localparam logic [1:0] SIDE_YN = 2'd2;
	localparam logic [1:0] SIDE_YP = 2'd3;

	typedef struct packed {
		logic        action;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [3:0]  cell_code;
		logic        x_step_negative;
		logic        y_step_negative;
		logic [31:0] side_dist_x;
		logic [31:0] side_dist_y;
		logic [31:0] delta_dist_x;
		logic [31:0] delta_dist_y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  hit_x;
		logic [5:0]  hit_y;
		logic [1:0]  wall_side;
		logic [3:0]  hit_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [31:0] final_dist_x;
		logic [31:0] final_dist_y;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_DISPATCH,
		OP_START,
		OP_STEP,
		OP_CHECK,
		OP_WRITE,
		OP_DONE,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		JC_ALWAYS,
		JC_ACCEPT,
		JC_IS_WRITE,
		JC_OFF_MAP,
		JC_LEAVE,
		JC_STOP,
		JC_OUT_BUSY
	} jc_t;

	typedef struct packed {
		op_t  op;
		jc_t  jc;
		upc_t jump;
		upc_t next;
	} uword_t;

	typedef struct packed {
		logic accept;
		logic is_write;
		logic off_map;
		logic leave;
		logic stop;
		logic out_busy;
	} flags_t;

	function automatic logic [23:0] wall_colour(input logic [1:0] side, input logic [2:0] idx);
		logic [23:0] c;
		c = 24'h000000;
		case (side)
			SIDE_XN: begin
				case (idx)
					3'd0: c = 24'h008100;
					3'd1: c = 24'h81FF81;
					3'd2: c = 24'h81FF81;
					3'd3: c = 24'h810000;
					3'd4: c = 24'h000081;
					default: c = 24'h000000;
				endcase
			end
			SIDE_XP: begin
				case (idx)
					3'd0: c = 24'h008181;
					3'd1: c = 24'h818181;
					3'd2: c = 24'h818181;
					3'd3: c = 24'h818100;
					3'd4: c = 24'h810081;
					default: c = 24'h000000;
				endcase
			end
			SIDE_YN: begin
				case (idx)
					3'd0: c = 24'h00FF00;
					3'd1: c = 24'hFFFFFF;
					3'd2: c = 24'hFFFFFF;
					3'd3: c = 24'hFF0000;
					3'd4: c = 24'h0000FF;
					default: c = 24'h000000;
				endcase
			end
			default: begin
				case (idx)
					3'd0: c = 24'h00FFFF;
					3'd1: c = 24'hFF81FF;
					3'd2: c = 24'hFF81FF;
					3'd3: c = 24'hFFFF00;
					3'd4: c = 24'hFF00FF;
					default: c = 24'h000000;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

// File: design/grd_seq.sv
// Microcode sequencer of the grid ray walker: microprogram counter, control store and
// conditional jumps. Depends on grd_pkg.
module grd_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  grd_pkg::flags_t flags,
	output grd_pkg::uword_t ctrl
);

	localparam grd_pkg::upc_t UA_IDLE     = 3'd0;
	localparam grd_pkg::upc_t UA_DISPATCH = 3'd1;
	localparam grd_pkg::upc_t UA_START    = 3'd2;
	localparam grd_pkg::upc_t UA_STEP     = 3'd3;
	localparam grd_pkg::upc_t UA_CHECK    = 3'd4;
	localparam grd_pkg::upc_t UA_WRITE    = 3'd5;
	localparam grd_pkg::upc_t UA_DONE     = 3'd6;
	localparam grd_pkg::upc_t UA_SPARE    = 3'd7;

	grd_pkg::upc_t upc_q;
	grd_pkg::upc_t upc_nxt;
	logic          taken;

	always_comb begin
		case (upc_q)
			UA_IDLE:     ctrl = '{grd_pkg::OP_IDLE, grd_pkg::JC_ACCEPT, UA_DISPATCH, UA_IDLE};
			UA_DISPATCH: ctrl = '{grd_pkg::OP_DISPATCH, grd_pkg::JC_IS_WRITE, UA_WRITE, UA_START};
			UA_START:    ctrl = '{grd_pkg::OP_START, grd_pkg::JC_OFF_MAP, UA_DONE, UA_STEP};
			UA_STEP:     ctrl = '{grd_pkg::OP_STEP, grd_pkg::JC_LEAVE, UA_DONE, UA_CHECK};
			UA_CHECK:    ctrl = '{grd_pkg::OP_CHECK, grd_pkg::JC_STOP, UA_DONE, UA_STEP};
			UA_WRITE:    ctrl = '{grd_pkg::OP_WRITE, grd_pkg::JC_ALWAYS, UA_DONE, UA_DONE};
			UA_DONE:     ctrl = '{grd_pkg::OP_DONE, grd_pkg::JC_OUT_BUSY, UA_DONE, UA_IDLE};
			UA_SPARE:    ctrl = '{grd_pkg::OP_NOP, grd_pkg::JC_ALWAYS, UA_IDLE, UA_IDLE};
			default:     ctrl = '{grd_pkg::OP_NOP, grd_pkg::JC_ALWAYS, UA_IDLE, UA_IDLE};
		endcase
	end

	always_comb begin
		case (ctrl.jc)
			grd_pkg::JC_ALWAYS:   taken = 1'b1;
			grd_pkg::JC_ACCEPT:   taken = flags.accept;
			grd_pkg::JC_IS_WRITE: taken = flags.is_write;
			grd_pkg::JC_OFF_MAP:  taken = flags.off_map;
			grd_pkg::JC_LEAVE:    taken = flags.leave;
			grd_pkg::JC_STOP:     taken = flags.stop;
			grd_pkg::JC_OUT_BUSY: taken = flags.out_busy;
			default:              taken = 1'b1;
		endcase
		upc_nxt = taken ? ctrl.jump : ctrl.next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

// File: design/grid_ray_dda_walker.sv
// Grid ray walker top level: map memory, walk datapath and output register.
// Depends on grd_pkg and grd_seq.
// A write beat passes the dispatch, write and done states; a cast passes dispatch and
// start, then a move and a read check per grid step (no check when it leaves the map).
// Once the result is registered the walker goes back to idle and takes the next command.
// Reset: cmd_stall stays high while a clearing pass zeroes the map, one cell per cycle.
module grid_ray_dda_walker #(
	parameter int MAP_WIDTH  = 64,
	parameter int MAP_HEIGHT = 64,
	parameter int CODE_BITS  = 4,
	parameter int DIST_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  grd_pkg::cfg_index_t                 cfg_index,
	input  logic [grd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  grd_pkg::cmd_t                       cmd,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output grd_pkg::rsp_t                       rsp
);

	localparam int XW        = ($clog2(MAP_WIDTH) > 6) ? $clog2(MAP_WIDTH) : 6;
	localparam int YW        = ($clog2(MAP_HEIGHT) > 6) ? $clog2(MAP_HEIGHT) : 6;
	localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW        = $clog2(MAP_CELLS);
	localparam int DW        = DIST_BITS;

	grd_pkg::uword_t ctrl;
	grd_pkg::flags_t flags;

	logic [CODE_BITS-1:0] map_mem [MAP_CELLS];

	logic [XW-1:0]        x_q, x_nxt;
	logic [YW-1:0]        y_q, y_nxt;
	logic [AW-1:0]        addr_q, addr_nxt, rd_addr, wr_addr, clr_addr_q;
	logic                 clr_busy_q;
	logic                 x_neg_q, y_neg_q, action_q;
	logic [3:0]           wcode_q;
	logic [DW-1:0]        dx_q, dy_q, ddx_q, ddy_q, add_a, add_b, sat_sum;
	logic [DW:0]          sum;
	logic                 go_x, leave, on_map, hit, limit_hit, colour_code;
	logic [1:0]           side_q, side_nxt, status_q;
	logic [CODE_BITS-1:0] code_q, rd_q, wr_data;
	logic                 wr_en;
	logic [11:0]          max_steps_q;
	logic [3:0]           see_q;
	logic [12:0]          steps_q, limit;
	logic [23:0]          colour_q;
	logic                 load_rsp, rsp_valid_q;
	grd_pkg::rsp_t        rsp_q;

	grd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	always_comb begin
		on_map = (32'(x_q) < 32'(MAP_WIDTH)) && (32'(y_q) < 32'(MAP_HEIGHT));
		go_x   = dx_q < dy_q;
		add_a  = go_x ? dx_q : dy_q;
		add_b  = go_x ? ddx_q : ddy_q;
		sum    = {1'b0, add_a} + {1'b0, add_b};
		sat_sum = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
		x_nxt  = x_q;
		y_nxt  = y_q;
		if (go_x) begin
			side_nxt = x_neg_q ? grd_pkg::SIDE_XN : grd_pkg::SIDE_XP;
			leave    = x_neg_q ? (x_q == '0) : (32'(x_q) == 32'(MAP_WIDTH - 1));
			x_nxt    = x_neg_q ? x_q - XW'(1) : x_q + XW'(1);
			addr_nxt = x_neg_q ? addr_q - AW'(1) : addr_q + AW'(1);
		end else begin
			side_nxt = y_neg_q ? grd_pkg::SIDE_YN : grd_pkg::SIDE_YP;
			leave    = y_neg_q ? (y_q == '0) : (32'(y_q) == 32'(MAP_HEIGHT - 1));
			y_nxt    = y_neg_q ? y_q - YW'(1) : y_q + YW'(1);
			addr_nxt = y_neg_q ? addr_q - AW'(MAP_WIDTH) : addr_q + AW'(MAP_WIDTH);
		end
		limit       = (max_steps_q == '0) ? grd_pkg::STEP_LIMIT_ZERO : {1'b0, max_steps_q};
		hit         = (rd_q != '0) && (8'(rd_q) != 8'(see_q));
		limit_hit   = steps_q >= limit;
		colour_code = (rd_q != '0) && (8'(rd_q) <= grd_pkg::COLOUR_CODES);
	end

	always_comb begin
		cmd_stall      = clr_busy_q || (ctrl.op != grd_pkg::OP_IDLE);
		flags.accept   = cmd_valid && !cmd_stall;
		flags.is_write = !action_q;
		flags.off_map  = !on_map;
		flags.leave    = leave;
		flags.stop     = hit || limit_hit;
		flags.out_busy = rsp_valid_q && rsp_stall;
		load_rsp       = (ctrl.op == grd_pkg::OP_DONE) && !flags.out_busy;
	end

	always_comb begin
		rd_addr = ((ctrl.op == grd_pkg::OP_STEP) && !leave) ? addr_nxt : addr_q;
		wr_addr = clr_busy_q ? clr_addr_q : addr_q;
		wr_data = clr_busy_q ? '0 : CODE_BITS'(wcode_q);
		wr_en   = clr_busy_q || ((ctrl.op == grd_pkg::OP_WRITE) && on_map);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		rd_q <= map_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			grd_pkg::OP_IDLE: begin
				if (flags.accept) begin
					action_q <= cmd.action;
					x_q      <= XW'(cmd.cell_x);
					y_q      <= YW'(cmd.cell_y);
					addr_q   <= AW'(32'(cmd.cell_y) * 32'(MAP_WIDTH) + 32'(cmd.cell_x));
					wcode_q  <= cmd.cell_code;
					x_neg_q  <= cmd.x_step_negative;
					y_neg_q  <= cmd.y_step_negative;
					dx_q     <= cmd.action ? DW'(cmd.side_dist_x) : '0;
					dy_q     <= cmd.action ? DW'(cmd.side_dist_y) : '0;
					ddx_q    <= DW'(cmd.delta_dist_x);
					ddy_q    <= DW'(cmd.delta_dist_y);
					code_q   <= '0;
					side_q   <= grd_pkg::SIDE_XN;
					steps_q  <= '0;
					status_q <= grd_pkg::ST_WRITTEN;
				end
			end
			grd_pkg::OP_START: begin
				status_q <= grd_pkg::ST_LEFT;
			end
			grd_pkg::OP_STEP: begin
				if (go_x) begin
					dx_q <= sat_sum;
				end else begin
					dy_q <= sat_sum;
				end
				side_q   <= side_nxt;
				steps_q  <= steps_q + 13'd1;
				code_q   <= rd_q;
				status_q <= grd_pkg::ST_LEFT;
				if (!leave) begin
					x_q    <= x_nxt;
					y_q    <= y_nxt;
					addr_q <= addr_nxt;
				end
			end
			grd_pkg::OP_CHECK: begin
				code_q   <= rd_q;
				status_q <= hit ? grd_pkg::ST_HIT : grd_pkg::ST_LIMIT;
			end
			grd_pkg::OP_WRITE: begin
				code_q <= on_map ? CODE_BITS'(wcode_q) : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			max_steps_q <= grd_pkg::MAX_STEPS_RESET;
			see_q       <= grd_pkg::SEE_THROUGH_RESET;
			colour_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MAP_CELLS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					grd_pkg::CFG_MAX_STEPS:   max_steps_q <= cfg_data[11:0];
					grd_pkg::CFG_SEE_THROUGH: see_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if ((ctrl.op == grd_pkg::OP_CHECK) && hit && colour_code) begin
				colour_q <= grd_pkg::wall_colour(side_q, 3'(rd_q - CODE_BITS'(1)));
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status       <= status_q;
			rsp_q.hit_x        <= x_q[5:0];
			rsp_q.hit_y        <= y_q[5:0];
			rsp_q.wall_side    <= side_q;
			rsp_q.hit_code     <= 4'(code_q);
			rsp_q.red          <= colour_q[23:16];
			rsp_q.green        <= colour_q[15:8];
			rsp_q.blue         <= colour_q[7:0];
			rsp_q.final_dist_x <= 32'(dx_q);
			rsp_q.final_dist_y <= 32'(dy_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/grd_chk.sv
// Port checker for the grid ray walker and its bind to the top level.
// Depends on grd_pkg.
module grd_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input grd_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result beat changed or vanished.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("Command beat taken while the previous one is in work.");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> !$rose(rsp_valid))
		else $error("Result beat appeared right after a command beat.");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == grd_pkg::ST_WRITTEN) |->
			(rsp.wall_side == grd_pkg::SIDE_XN) && (rsp.final_dist_x == 32'd0) &&
			(rsp.final_dist_y == 32'd0))
		else $error("Write result beat carries walk data.");

endmodule

bind grid_ray_dda_walker grd_chk u_grd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_ray_dda_walker: map writes and ray casts are
// checked against a behavioral walker kept in the bench. Depends on grd_pkg.
module testbench;

	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;
	localparam int   MAP_DIM   = 64;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	// Wall colors, side-major then code 1 to 5, first entry in the top bits.
	localparam logic [20*24-1:0] WALL_RGB = {
		24'h008100, 24'h81FF81, 24'h81FF81, 24'h810000, 24'h000081,
		24'h008181, 24'h818181, 24'h818181, 24'h818100, 24'h810081,
		24'h00FF00, 24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'h0000FF,
		24'h00FFFF, 24'hFF81FF, 24'hFF81FF, 24'hFFFF00, 24'hFF00FF
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	grd_pkg::cfg_index_t cfg_index = grd_pkg::CFG_MAX_STEPS;
	logic [grd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	grd_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	grd_pkg::rsp_t rsp;

	logic [3:0] map_mirror [MAP_DIM*MAP_DIM];
	logic [23:0] colour_mirror = 24'h0;
	logic [11:0] step_cap = grd_pkg::MAX_STEPS_RESET;
	logic [3:0] pass_code = grd_pkg::SEE_THROUGH_RESET;

	grd_pkg::cmd_t cmd_pending_q [$];
	grd_pkg::rsp_t expected_rsp_q [$];
	grd_pkg::rsp_t want;
	int idle_pct = 0;
	int gap_left = 0;
	int hold_left = 0;
	int mismatches = 0;
	int n_store = 0, n_hit = 0, n_left = 0, n_limit = 0;
	int unsigned cycle_count = 0;

	grid_ray_dda_walker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial forever #2 clk = ~clk;

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [11:0] cell_index(input int x, input int y);
		return 12'(y*MAP_DIM + x);
	endfunction

	// Applies one command beat to the mirrored map and color and returns its result.
	function automatic grd_pkg::rsp_t predict_beat(input grd_pkg::cmd_t c);
		grd_pkg::rsp_t r;
		int x, y, nx, ny, steps, limit;
		logic [31:0] dx, dy;
		logic [1:0] side, status;
		logic [3:0] code;
		bit done;
		x = int'(c.cell_x);
		y = int'(c.cell_y);
		dx = 32'h0;
		dy = 32'h0;
		side = grd_pkg::SIDE_XN;
		code = 4'h0;
		if (c.action == ACT_STORE) begin
			status = grd_pkg::ST_WRITTEN;
			code = c.cell_code;
			map_mirror[cell_index(x, y)] = code;
		end else begin
			dx = c.side_dist_x;
			dy = c.side_dist_y;
			limit = (step_cap == 12'd0) ? int'(grd_pkg::STEP_LIMIT_ZERO) : int'(step_cap);
			steps = 0;
			done = 1'b0;
			status = grd_pkg::ST_LEFT;
			while (!done) begin
				nx = x;
				ny = y;
				if (dx < dy) begin
					dx = sat_sum(dx, c.delta_dist_x);
					nx = c.x_step_negative ? x - 1 : x + 1;
					side = c.x_step_negative ? grd_pkg::SIDE_XN : grd_pkg::SIDE_XP;
				end else begin
					dy = sat_sum(dy, c.delta_dist_y);
					ny = c.y_step_negative ? y - 1 : y + 1;
					side = c.y_step_negative ? grd_pkg::SIDE_YN : grd_pkg::SIDE_YP;
				end
				steps++;
				if (nx < 0 || nx >= MAP_DIM || ny < 0 || ny >= MAP_DIM) begin
					status = grd_pkg::ST_LEFT;
					code = map_mirror[cell_index(x, y)];
					done = 1'b1;
				end else begin
					x = nx;
					y = ny;
					code = map_mirror[cell_index(x, y)];
					if (code != 4'h0 && code != pass_code) begin
						status = grd_pkg::ST_HIT;
						if (code >= 4'd1 && 8'(code) <= grd_pkg::COLOUR_CODES)
							colour_mirror = WALL_RGB[(19 - (int'(side)*5 + int'(code) - 1))*24 +: 24];
						done = 1'b1;
					end else if (steps >= limit) begin
						status = grd_pkg::ST_LIMIT;
						done = 1'b1;
					end
				end
			end
		end
		r.status = status;
		r.hit_x = x[5:0];
		r.hit_y = y[5:0];
		r.wall_side = side;
		r.hit_code = code;
		r.red = colour_mirror[23:16];
		r.green = colour_mirror[15:8];
		r.blue = colour_mirror[7:0];
		r.final_dist_x = dx;
		r.final_dist_y = dy;
		return r;
	endfunction

	function automatic grd_pkg::cmd_t store_beat(input int x, input int y, input int code);
		grd_pkg::cmd_t c;
		c.action = ACT_STORE;
		c.cell_x = 6'(x);
		c.cell_y = 6'(y);
		c.cell_code = 4'(code);
		c.x_step_negative = 1'($urandom);
		c.y_step_negative = 1'($urandom);
		c.side_dist_x = $urandom;
		c.side_dist_y = $urandom;
		c.delta_dist_x = $urandom;
		c.delta_dist_y = $urandom;
		return c;
	endfunction

	function automatic grd_pkg::cmd_t cast_beat(input int x, input int y,
			input int xn, input int yn, input logic [31:0] sdx, input logic [31:0] sdy,
			input logic [31:0] ddx, input logic [31:0] ddy);
		grd_pkg::cmd_t c;
		c.action = ACT_CAST;
		c.cell_x = 6'(x);
		c.cell_y = 6'(y);
		c.cell_code = 4'($urandom);
		c.x_step_negative = 1'(xn);
		c.y_step_negative = 1'(yn);
		c.side_dist_x = sdx;
		c.side_dist_y = sdy;
		c.delta_dist_x = ddx;
		c.delta_dist_y = ddy;
		return c;
	endfunction

	// Most beats land in a 16 x 16 window so that stored walls actually get hit.
	function automatic grd_pkg::cmd_t random_beat();
		grd_pkg::cmd_t c;
		int pick;
		c.action = ($urandom_range(0, 99) < 35) ? ACT_STORE : ACT_CAST;
		if ($urandom_range(0, 99) < 75) begin
			c.cell_x = 6'd24 + 6'($urandom_range(0, 15));
			c.cell_y = 6'd24 + 6'($urandom_range(0, 15));
		end else begin
			c.cell_x = 6'($urandom);
			c.cell_y = 6'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 35)
			c.cell_code = 4'h0;
		else if (pick < 70)
			c.cell_code = 4'($urandom_range(1, 5));
		else if (pick < 80)
			c.cell_code = pass_code;
		else
			c.cell_code = 4'($urandom);
		c.x_step_negative = 1'($urandom);
		c.y_step_negative = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			c.delta_dist_x = $urandom_range(32'h8000, 32'h60000);
			c.delta_dist_y = $urandom_range(32'h8000, 32'h60000);
			c.side_dist_x = $urandom_range(0, c.delta_dist_x);
			c.side_dist_y = $urandom_range(0, c.delta_dist_y);
		end else if (pick < 88) begin
			c.delta_dist_x = $urandom;
			c.delta_dist_y = $urandom;
			c.side_dist_x = $urandom;
			c.side_dist_y = $urandom;
		end else begin
			c.delta_dist_x = 32'hF000_0000 | $urandom;
			c.delta_dist_y = 32'hF000_0000 | $urandom;
			c.side_dist_x = 32'hFFFF_0000 | $urandom_range(0, 65535);
			c.side_dist_y = 32'hFFFF_0000 | $urandom_range(0, 65535);
		end
		return c;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
			mismatches++;
		end
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (cmd_pending_q.size() != 0 || cmd_valid || expected_rsp_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_registers(input logic [11:0] steps_val, input logic [3:0] pass_val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= grd_pkg::CFG_MAX_STEPS;
		cfg_data <= steps_val;
		@(posedge clk);
		cfg_index <= grd_pkg::CFG_SEE_THROUGH;
		cfg_data <= {8'd0, pass_val};
		@(posedge clk);
		cfg_we <= 1'b0;
		step_cap = steps_val;
		pass_code = pass_val;
	endtask

	task automatic run_random(input logic [11:0] steps_val, input logic [3:0] pass_val,
			input int idle, input int count);
		wait_drained();
		set_registers(steps_val, pass_val);
		idle_pct = idle;
		repeat (count) cmd_pending_q.push_back(random_beat());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				expected_rsp_q.push_back(predict_beat(cmd));
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					cmd_valid <= 1'b0;
				end else if (cmd_pending_q.size() != 0 && idle_pct > 0
						&& $urandom_range(0, 99) < idle_pct) begin
					gap_left <= $urandom_range(0, 2);
					cmd_valid <= 1'b0;
				end else if (cmd_pending_q.size() != 0) begin
					cmd <= cmd_pending_q.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, expected none, got %h",
						$time, rsp);
					mismatches++;
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("hit_x", 32'(want.hit_x), 32'(rsp.hit_x));
					check_field("hit_y", 32'(want.hit_y), 32'(rsp.hit_y));
					check_field("wall_side", 32'(want.wall_side), 32'(rsp.wall_side));
					check_field("hit_code", 32'(want.hit_code), 32'(rsp.hit_code));
					check_field("red", 32'(want.red), 32'(rsp.red));
					check_field("green", 32'(want.green), 32'(rsp.green));
					check_field("blue", 32'(want.blue), 32'(rsp.blue));
					check_field("final_dist_x", want.final_dist_x, rsp.final_dist_x);
					check_field("final_dist_y", want.final_dist_y, rsp.final_dist_y);
					case (want.status)
						grd_pkg::ST_WRITTEN: n_store++;
						grd_pkg::ST_HIT:     n_hit++;
						grd_pkg::ST_LEFT:    n_left++;
						default:             n_limit++;
					endcase
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				hold_left <= $urandom_range(0, 2);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: run stopped at the cycle limit", $time);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAP_DIM*MAP_DIM; i++)
			map_mirror[12'(i)] = 4'h0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 20;

		// Reset register values: map exits on all four sides, see-through cells, each color
		// code from 1 to 5, an unlisted code, ties and saturation.
		cmd_pending_q.push_back(cast_beat(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 32'h10000));
		cmd_pending_q.push_back(store_beat(5, 0, 1));
		cmd_pending_q.push_back(store_beat(3, 0, 6));
		cmd_pending_q.push_back(cast_beat(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 32'h10000));
		cmd_pending_q.push_back(store_beat(63, 63, 15));
		cmd_pending_q.push_back(cast_beat(63, 0, 1, 0, 32'hFFFF_FFFF, 0, 32'h10000, 32'h8000));
		cmd_pending_q.push_back(store_beat(0, 63, 5));
		cmd_pending_q.push_back(cast_beat(0, 0, 0, 0, 0, 0, 0, 0));
		cmd_pending_q.push_back(cast_beat(63, 63, 1, 1, 0, 32'hFFFF_FFFF, 32'h10000, 0));
		cmd_pending_q.push_back(cast_beat(10, 10, 0, 1, 32'hFFFF_FFFF, 0, 0, 32'h20000));
		cmd_pending_q.push_back(cast_beat(20, 20, 0, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		cmd_pending_q.push_back(store_beat(32, 40, 3));
		cmd_pending_q.push_back(cast_beat(32, 32, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h18000));
		cmd_pending_q.push_back(store_beat(40, 32, 4));
		cmd_pending_q.push_back(cast_beat(32, 32, 0, 0, 0, 32'hFFFF_FFFF, 32'h18000, 0));
		cmd_pending_q.push_back(store_beat(24, 32, 2));
		cmd_pending_q.push_back(cast_beat(32, 32, 1, 0, 0, 32'hFFFF_FFFF, 32'h18000, 0));
		cmd_pending_q.push_back(store_beat(32, 24, 9));
		cmd_pending_q.push_back(cast_beat(32, 32, 0, 1, 32'hFFFF_FFFF, 0, 0, 32'h18000));
		cmd_pending_q.push_back(store_beat(0, 0, 0));
		cmd_pending_q.push_back(cast_beat(30, 30, 1, 1, 32'h8000, 32'h8000, 32'h1_6A09,
			32'h1_6A09));

		// Short step limit, and code 6 turned into a wall with no color entry.
		wait_drained();
		set_registers(12'd3, 4'd0);
		cmd_pending_q.push_back(cast_beat(32, 32, 0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 0));
		cmd_pending_q.push_back(cast_beat(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 0));

		wait_drained();
		set_registers(12'd1, 4'd15);
		cmd_pending_q.push_back(cast_beat(32, 32, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h10000));

		// A limit of zero never stops the walk; code 15 is now passed through.
		wait_drained();
		set_registers(12'd0, 4'd15);
		cmd_pending_q.push_back(cast_beat(63, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h10000));
		cmd_pending_q.push_back(cast_beat(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 0));

		run_random(12'd4095, 4'd6, 25, 84);
		run_random(12'd5, 4'd0, 15, 60);
		run_random(12'd12, 4'd9, 40, 90);
		run_random(12'd256, 4'd15, 0, 60);
		run_random(12'd200, 4'd6, 20, 80);
		run_random(12'd4095, 4'd3, 0, 50);

		wait_drained();
		repeat (300) @(posedge clk);
		mismatches += expected_rsp_q.size();
		$display("Checked %0d result beats: %0d map writes, %0d wall hits, %0d map exits,",
			n_store + n_hit + n_left + n_limit, n_store, n_hit, n_left);
		$display("and %0d step-limit stops over ten register configurations.", n_limit);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: sim.f
design/grd_pkg.sv
design/grd_seq.sv
design/grid_ray_dda_walker.sv
design/grd_chk.sv
tb/testbench.sv
